### hdl/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// shared constants and controller/datapath command and status types for the
// lru cache table
// ----------------------------------------------------------------------------
package lct_pkg;

    localparam int DEF_ENTRIES     = 16;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int              CFG_WIDTH   = 5;
    localparam [CFG_WIDTH-1:0]  LIMIT_RESET = 5'd16;

    // operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic capture;      // latch the incoming request
        logic lookup;       // compare keys and pick the target slot
        logic apply;        // update stores and ranks
        logic load_result;  // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;     // output register empty or being taken
    } t_dp_status;

endpackage

### hdl/lru_cache_table_top.sv
// ----------------------------------------------------------------------------
// lru_cache_table_top
// fully associative key/value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   i_valid / o_ready          i_func, i_lookup_key, i_write_value
//  result    o_valid / i_ready          o_hit, o_read_value
//  config    i_cfg_valid / o_cfg_ready  i_cfg_data (entry limit)
//
//  one request at a time: accept, lookup, update, result load, so a new
//  request is not taken before the previous one has loaded its result
//  the next request is taken the cycle after the result is loaded; the result
//  sits in its own register, so a stalled result blocks only the result load
//  synchronous active-low reset empties the table at once, no clearing pass
//  config writes are always taken
// ----------------------------------------------------------------------------
module lru_cache_table_top #(
    parameter int ENTRIES     = lct_pkg::DEF_ENTRIES,
    parameter int KEY_WIDTH   = lct_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lct_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [KEY_WIDTH-1:0]          i_lookup_key,
    input  logic [VALUE_WIDTH-1:0]        i_write_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [VALUE_WIDTH-1:0]        o_read_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lct_pkg::CFG_WIDTH-1:0] i_cfg_data
);
    import lct_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    lct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lct_datapath #(
        .ENTRIES     (ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_func        (i_func),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

endmodule

### hdl/lct_ctrl.sv
// ----------------------------------------------------------------------------
// lct_ctrl
// sequencer: accept one request, run lookup and update, hand over the result
// ----------------------------------------------------------------------------
module lct_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lct_pkg::t_dp_status i_status,
    output lct_pkg::t_dp_cmd    o_cmd
);
    import lct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_APPLY  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_APPLY;
            S_APPLY:  n_state = S_RESULT;
            S_RESULT: if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_cmd.capture     = (r_state == S_IDLE) && i_valid;
    assign o_cmd.lookup      = (r_state == S_LOOKUP);
    assign o_cmd.apply       = (r_state == S_APPLY);
    assign o_cmd.load_result = (r_state == S_RESULT) && i_status.out_free;

endmodule

### hdl/lct_datapath.sv
// ----------------------------------------------------------------------------
// lct_datapath
// key cam, recency ranks, value memory, limit register and output register
// ----------------------------------------------------------------------------
module lct_datapath #(
    parameter int ENTRIES     = lct_pkg::DEF_ENTRIES,
    parameter int KEY_WIDTH   = lct_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lct_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lct_pkg::t_dp_cmd              i_cmd,
    output lct_pkg::t_dp_status           o_status,
    input  logic                          i_func,
    input  logic [KEY_WIDTH-1:0]          i_lookup_key,
    input  logic [VALUE_WIDTH-1:0]        i_write_value,
    input  logic                          i_cfg_valid,
    input  logic [lct_pkg::CFG_WIDTH-1:0] i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [VALUE_WIDTH-1:0]        o_read_value
);
    import lct_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CFG_WIDTH) ? CNT_W : CFG_WIDTH;
    localparam [CMP_W-1:0] ENT_C = CMP_W'(ENTRIES);

    // request
    logic                   r_func;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_wval;

    // table state
    logic [KEY_WIDTH-1:0]   r_key_store [ENTRIES];
    logic [RANK_W-1:0]      r_rank      [ENTRIES];
    logic [ENTRIES-1:0]     r_entry_valid;
    logic [CNT_W-1:0]       r_count;
    logic [CFG_WIDTH-1:0]   r_limit;

    // value memory
    logic [VALUE_WIDTH-1:0] mem_value [ENTRIES];
    logic [VALUE_WIDTH-1:0] r_rd_data;

    // lookup results
    logic                   r_hit;
    logic                   r_evict;
    logic [IDX_W-1:0]       r_tgt_idx;
    logic [RANK_W-1:0]      r_old_rank;

    // output register
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [VALUE_WIDTH-1:0] r_out_value;

    // lookup logic
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] oldest;
    logic [IDX_W-1:0]   hit_idx, victim_idx, free_idx, tgt_idx;
    logic [RANK_W-1:0]  hit_rank, last_rank;
    logic [CMP_W-1:0]   lim_ext, lim_eff;
    logic               any_hit, evict;

    assign last_rank = RANK_W'(r_count - 1'b1);

    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        hit_rank   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_entry_valid[i] && (r_key_store[i] == r_key);
            // ranks form a permutation of 0..count-1, so the oldest is unique
            oldest[i] = r_entry_valid[i] && (r_rank[i] == last_rank);
            if (match[i]) hit_rank = hit_rank | r_rank[i];
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i])          hit_idx    = IDX_W'(i);
            if (oldest[i])         victim_idx = IDX_W'(i);
            if (!r_entry_valid[i]) free_idx   = IDX_W'(i);
        end
    end

    always_comb begin
        lim_ext = CMP_W'(r_limit);
        if (lim_ext == '0) begin
            lim_eff = CMP_W'(1);
        end else if (lim_ext > ENT_C) begin
            lim_eff = ENT_C;
        end else begin
            lim_eff = lim_ext;
        end
        any_hit = |match;
        evict   = (CMP_W'(r_count) >= lim_eff);
        if (any_hit) begin
            tgt_idx = hit_idx;
        end else if (evict) begin
            tgt_idx = victim_idx;
        end else begin
            tgt_idx = free_idx;
        end
    end

    // update decode
    logic is_put, do_promote, do_insert, key_wr;
    assign is_put     = (r_func == FUNC_PUT);
    assign do_promote = r_hit || (is_put && r_evict);
    assign do_insert  = is_put && !r_hit && !r_evict;
    assign key_wr     = is_put && !r_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_key  <= i_lookup_key;
            r_wval <= i_write_value;
        end
        if (i_cmd.lookup) begin
            r_hit      <= any_hit;
            r_evict    <= evict;
            r_tgt_idx  <= tgt_idx;
            r_old_rank <= any_hit ? hit_rank : last_rank;
        end
        if (i_cmd.apply && key_wr) begin
            r_key_store[r_tgt_idx] <= r_key;
        end
    end

    // valid bits, ranks, occupancy and limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_count       <= '0;
            r_limit       <= LIMIT_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.apply && do_promote) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_tgt_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_entry_valid[i] && (r_rank[i] < r_old_rank)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
            if (i_cmd.apply && do_insert) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == r_tgt_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_entry_valid[i]) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                r_entry_valid[r_tgt_idx] <= 1'b1;
                r_count                  <= r_count + 1'b1;
            end
        end
    end

    // value memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && is_put) begin
            mem_value[r_tgt_idx] <= r_wval;
        end
        if (i_cmd.apply && !is_put && r_hit) begin
            r_rd_data <= mem_value[r_tgt_idx];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_hit   <= r_hit;
            r_out_value <= (r_hit && !is_put) ? r_rd_data : '0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_read_value      = r_out_value;

    // checks
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_entry_valid)))
        else $error("occupancy differs from number of valid entries");

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("key present in more than one entry");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_result |-> (!r_out_valid || i_ready))
        else $error("result loaded over one not yet taken");

    a_insert_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && do_insert) |-> !r_entry_valid[r_tgt_idx])
        else $error("insert into an occupied slot");

endmodule
